// ===== design/tdc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdc_pkg: shared types for the triple dedupe/compact block
// Transaction record that travels down the cell chain.
// ----------------------------------------------------------------------------
package tdc_pkg;

	localparam int KEY_W = 24;
	localparam int POS_W = 8;
	localparam int CNT_W = 9;

	typedef struct packed {
		logic             vld;
		logic [7:0]       val;
		logic [7:0]       row;
		logic [7:0]       col;
		logic             last;
		logic             res;   // resolved: hit or stored upstream
		logic             keep;
		logic [POS_W-1:0] pos;
	} item_t;

endpackage

// ===== design/tdc_cell.sv =====
// ----------------------------------------------------------------------------
// tdc_cell: one table slot of the dedupe chain
// Holds one kept triple, checks the passing transaction against it, claims
// the slot when it is the next free one, and forwards the transaction.
// ----------------------------------------------------------------------------
module tdc_cell #(
	parameter int IDX = 0,
	parameter int FW  = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [FW-1:0]     fill,
	input  tdc_pkg::item_t    up,
	output tdc_pkg::item_t    dn,
	output logic              store
);

	localparam logic [FW-1:0]            IDX_W = FW'(IDX);
	localparam logic [tdc_pkg::POS_W-1:0] IDX_P = tdc_pkg::POS_W'(IDX);

	logic [tdc_pkg::KEY_W-1:0] entry_q;
	logic [tdc_pkg::KEY_W-1:0] key;
	tdc_pkg::item_t            item_q;
	tdc_pkg::item_t            nxt;
	logic                      vld_q;
	logic                      live;
	logic                      hit;

	assign key   = {up.val, up.row, up.col};
	assign live  = up.vld && !up.res;
	assign hit   = live && (IDX_W < fill) && (entry_q == key);
	assign store = live && (IDX_W == fill);

	always_comb begin
		nxt      = up;
		nxt.res  = up.res | hit | store;
		nxt.keep = up.keep | store;
		if (store) begin
			nxt.pos = IDX_P;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= up.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_q <= nxt;
			if (store) begin
				entry_q <= key;
			end
		end
	end

	always_comb begin
		dn     = item_q;
		dn.vld = vld_q;
	end

endmodule

// ===== design/triple_dedupe_compact_top.sv =====
// ----------------------------------------------------------------------------
// triple_dedupe_compact_top: order-preserving dedupe of (value,row,col) lists
// Chain of MAX_ENTRIES table cells with an output register at the end.
// ----------------------------------------------------------------------------
// Each transaction walks a chain of MAX_ENTRIES cells, one cell per cycle while
// the chain is not frozen, and leaves through the output register. Within a
// list a new triple is taken every cycle while the output does not stall; the
// first-free cell claims a new triple, so every later triple of the list sees
// it. After the list_end triple is accepted, input stays stalled until that
// triple has left the chain and the table count is cleared. A stall on the
// output freezes the chain.
module triple_dedupe_compact_top #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] entry_value,
	input  logic [7:0] entry_row,
	input  logic [7:0] entry_col,
	input  logic       list_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       keep,
	output logic [7:0] out_value,
	output logic [7:0] out_row,
	output logic [7:0] out_col,
	output logic [7:0] position,
	output logic [8:0] distinct_count,
	output logic       list_done,
	output logic       overflow
);

	localparam int FW = $clog2(MAX_ENTRIES + 1);
	localparam logic [FW-1:0] MAX_W = FW'(MAX_ENTRIES);

	tdc_pkg::item_t link [MAX_ENTRIES+1];
	logic [MAX_ENTRIES-1:0] store_vec;
	logic [FW-1:0]          fill_q;
	logic [FW+8:0]          fill_ext;
	logic                   block_q;
	logic                   adv;
	logic                   in_acc;
	logic                   tail_last;
	logic                   out_vld_q;
	tdc_pkg::item_t         out_q;
	logic [8:0]             cnt_q;

	assign adv       = !out_vld_q || !out_stall;
	assign in_stall  = !adv || block_q;
	assign in_acc    = in_valid && !in_stall;
	assign tail_last = adv && link[MAX_ENTRIES].vld && link[MAX_ENTRIES].last;
	assign fill_ext  = {9'd0, fill_q};

	always_comb begin
		link[0]      = '0;
		link[0].vld  = in_acc;
		link[0].val  = entry_value;
		link[0].row  = entry_row;
		link[0].col  = entry_col;
		link[0].last = list_end;
	end

	for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
		tdc_cell #(
			.IDX (k),
			.FW  (FW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.fill   (fill_q),
			.up     (link[k]),
			.dn     (link[k+1]),
			.store  (store_vec[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (tail_last) begin
			fill_q <= '0;
		end else if (adv && (|store_vec)) begin
			fill_q <= fill_q + FW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_q <= 1'b0;
		end else if (in_acc && list_end) begin
			block_q <= 1'b1;
		end else if (tail_last) begin
			block_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= link[MAX_ENTRIES].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= link[MAX_ENTRIES];
			cnt_q <= link[MAX_ENTRIES].last ? fill_ext[8:0] : 9'd0;
		end
	end

	assign out_valid      = out_vld_q;
	assign keep           = out_q.keep;
	assign out_value      = out_q.val;
	assign out_row        = out_q.row;
	assign out_col        = out_q.col;
	assign position       = out_q.keep ? out_q.pos : 8'd0;
	assign distinct_count = cnt_q;
	assign list_done      = out_q.last;
	assign overflow       = !out_q.res;

	a_one_store: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(store_vec))
		else $error("more than one cell claimed a slot");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= MAX_W)
		else $error("table count beyond capacity");

	a_keep_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(keep && overflow))
		else $error("kept transaction flagged as overflow");

	a_block_clear: assert property (@(posedge clk) disable iff (!arst_n)
		tail_last |=> (fill_q == '0) || !block_q)
		else $error("table count not cleared at end of list");

endmodule

// ===== tb/sv/triple_dedupe_compact_top_tb.sv =====
// ----------------------------------------------------------------------------
// triple_dedupe_compact_top_tb: self-checking bench for the triple dedupe block
// Streams lists of (value,row,col) triples through the block, partly under random
// input idling and output stalls. A scoreboard keeps its own table of kept
// triples per list, predicts keep/position/count/overflow for every accepted
// transaction and checks each returned result in order. A 300-transaction
// list overfills the table while the output is held off for a long stretch.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic       keep;
	logic [7:0] value;
	logic [7:0] row;
	logic [7:0] col;
	logic [7:0] position;
	logic [8:0] distinct_count;
	logic       list_done;
	logic       overflow;
} dedupe_result_t;

class dedupe_scoreboard #(int DEPTH = 256);
	logic [23:0]    kept_keys [DEPTH];
	int             fill;
	dedupe_result_t pending_results [$];
	int             mismatches;

	function new();
		fill = 0;
		mismatches = 0;
	endfunction

	function string show(dedupe_result_t t);
		return $sformatf("keep=%0d val=%0d row=%0d col=%0d pos=%0d cnt=%0d done=%0d ovf=%0d",
			t.keep, t.value, t.row, t.col, t.position, t.distinct_count, t.list_done,
			t.overflow);
	endfunction

	function void add_triple(logic [7:0] v, logic [7:0] r, logic [7:0] c, logic last);
		dedupe_result_t e;
		logic [23:0]    key;
		bit             hit;
		key = {v, r, c};
		hit = 1'b0;
		for (int i = 0; i < fill; i++)
			if (kept_keys[i] == key) hit = 1'b1;
		e = '0;
		e.value = v;
		e.row = r;
		e.col = c;
		if (!hit) begin
			if (fill < DEPTH) begin
				e.keep = 1'b1;
				e.position = 8'(fill);
				kept_keys[fill] = key;
				fill++;
			end else begin
				e.overflow = 1'b1;
			end
		end
		if (last) begin
			e.list_done = 1'b1;
			e.distinct_count = 9'(fill);
			fill = 0;
		end
		pending_results.push_back(e);
	endfunction

	function void match_result(dedupe_result_t got);
		dedupe_result_t e;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: %s", show(got));
			return;
		end
		e = pending_results.pop_front();
		if (got !== e) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp %s / got %s", show(e), show(got));
		end
	endfunction

	function void report_missing();
		mismatches += pending_results.size();
		$display("%0d expected results never arrived, next: %s",
			pending_results.size(), show(pending_results[0]));
	endfunction
endclass

module triple_dedupe_compact_top_tb;

	localparam int TABLE_DEPTH = 256;
	localparam int ITEM_TARGET = 950;
	localparam int HOLD_CYCLES = 600;
	localparam int QUIET_LIMIT = 3000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] entry_value = 8'd1;
	logic [7:0] entry_row = 8'd0;
	logic [7:0] entry_col = 8'd0;
	logic       list_end = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       keep;
	logic [7:0] out_value;
	logic [7:0] out_row;
	logic [7:0] out_col;
	logic [7:0] position;
	logic [8:0] distinct_count;
	logic       list_done;
	logic       overflow;

	dedupe_scoreboard #(TABLE_DEPTH) sb;

	int send_idle_pct = 25;
	int recv_stall_pct = 47;
	int items_sent = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;

	triple_dedupe_compact_top #(.MAX_ENTRIES(TABLE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.entry_value(entry_value),
		.entry_row(entry_row),
		.entry_col(entry_col),
		.list_end(list_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.keep(keep),
		.out_value(out_value),
		.out_row(out_row),
		.out_col(out_col),
		.position(position),
		.distinct_count(distinct_count),
		.list_done(list_done),
		.overflow(overflow)
	);

	always #10 clk = ~clk;

	// receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			hold_req = 1'b0;
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		dedupe_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.keep = keep;
			got.value = out_value;
			got.row = out_row;
			got.col = out_col;
			got.position = position;
			got.distinct_count = distinct_count;
			got.list_done = list_done;
			got.overflow = overflow;
			sb.match_result(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("triple_dedupe_compact_top regression: fail");
			$finish;
		end
	end

	task automatic offer_triple(input logic [7:0] v, input logic [7:0] r,
			input logic [7:0] c, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		entry_value <= v;
		entry_row <= r;
		entry_col <= c;
		list_end <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.add_triple(v, r, c, last);
		items_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic run_short_list(input int len);
		logic [23:0] pool [4];
		logic [23:0] key;
		int          pick;
		for (int i = 0; i < 4; i++)
			pool[i] = {8'($urandom_range(255, 1)), 8'($urandom_range(255, 0)),
				8'($urandom_range(255, 0))};
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(9);
			key = pool[$urandom_range(3)];
			if (pick == 5)
				key[7:0] = key[7:0] ^ (8'd1 << $urandom_range(7));
			else if (pick == 6)
				key[15:8] = key[15:8] ^ (8'd1 << $urandom_range(7));
			else if (pick >= 7)
				key = {8'($urandom_range(255, 1)), 8'($urandom_range(255, 0)),
					8'($urandom_range(255, 0))};
			offer_triple(key[23:16], key[15:8], key[7:0], i == len - 1);
		end
	endtask

	// more distinct triples than the table holds, with repeats mixed in
	task automatic run_overfill_list();
		logic [23:0] sent [$];
		logic [23:0] key;
		logic [7:0]  salt;
		int          fresh;
		fresh = 0;
		salt = 8'($urandom_range(255, 0));
		hold_req = 1'b1;
		for (int i = 0; i < 300; i++) begin
			if (i % 9 == 8) begin
				key = sent[$urandom_range(sent.size() - 1)];
			end else begin
				key = {8'($urandom_range(255, 1)), 8'(fresh), 8'(fresh >> 8) ^ salt};
				sent.push_back(key);
				fresh++;
			end
			offer_triple(key[23:16], key[15:8], key[7:0], i == 299);
		end
	endtask

	initial begin
		int phase;
		int next_phase;
		sb = new();
		phase = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		offer_triple(8'd255, 8'd255, 8'd255, 1'b1);
		offer_triple(8'd1, 8'd0, 8'd0, 1'b0);
		offer_triple(8'd1, 8'd0, 8'd0, 1'b0);
		offer_triple(8'd1, 8'd0, 8'd1, 1'b0);
		offer_triple(8'd1, 8'd1, 8'd0, 1'b0);
		offer_triple(8'd2, 8'd0, 8'd0, 1'b0);
		offer_triple(8'd1, 8'd0, 8'd0, 1'b1);
		offer_triple(8'h55, 8'hAA, 8'h55, 1'b0);
		offer_triple(8'hAA, 8'h55, 8'hAA, 1'b0);
		offer_triple(8'h80, 8'h80, 8'h80, 1'b0);
		offer_triple(8'h55, 8'hAA, 8'h55, 1'b0);
		offer_triple(8'h7F, 8'h7F, 8'h7F, 1'b1);
		offer_triple(8'd255, 8'd255, 8'd255, 1'b1);

		drain_results();
		run_overfill_list();

		while (items_sent < ITEM_TARGET) begin
			next_phase = (3 * items_sent) / ITEM_TARGET;
			if (next_phase != phase) begin
				drain_results();
				phase = next_phase;
				send_idle_pct = (phase == 1) ? 47 : 0;
				recv_stall_pct = (phase == 1) ? 25 : 0;
			end
			run_short_list(($urandom_range(9) == 0) ? $urandom_range(60, 30)
				: $urandom_range(16, 1));
		end

		drain_results();
		repeat (TABLE_DEPTH + 10) @(posedge clk);
		if (sb.pending_results.size() != 0)
			sb.report_missing();
		if (sb.mismatches == 0)
			$display("triple_dedupe_compact_top regression: pass");
		else
			$display("triple_dedupe_compact_top regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
design/tdc_pkg.sv
design/tdc_cell.sv
design/triple_dedupe_compact_top.sv
tb/sv/triple_dedupe_compact_top_tb.sv
